FILE: design/nrs_pkg.sv
`timescale 1ns / 1ps

package nrs_pkg;

    // Field widths of the stepper's channels and registers.
    localparam int COEF_W     = 32;
    localparam int FRAC_BITS  = 30;
    localparam int WAVE_W     = 48;
    localparam int SEED_W     = 48;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 48;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_SEED_FIRST  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEED_SECOND = 2'd1;

    // One input beat: the scaled coefficient of a grid point.
    typedef struct packed {
        logic signed [COEF_W-1:0] coef_sample;
        logic                     restart;
    } t_in;

    // One output beat: the wavefunction value of a grid point.
    typedef struct packed {
        logic signed [WAVE_W-1:0] wave_value;
        logic                     saturated;
        logic                     zero_divisor;
    } t_out;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_NEG_LO,
        ST_NEG_HI,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } t_state;

endpackage

FILE: design/numerov_recurrence_stepper.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Beat
// input     in         i_in_valid / o_in_stall   nrs_pkg::t_in  (coef_sample, restart)
// output    out        o_out_valid / i_out_stall nrs_pkg::t_out (wave_value, flags)
// config    in         i_cfg_we                  i_cfg_addr, i_cfg_data
//
// Seed points go from the idle state straight to the done state.
// Recurrence points pass through the multiply, negate-low, negate-high,
// divide and finish states before the done state: a two-bit-per-cycle
// shift-and-add multiplier forms the numerator, then a two-bit-per-cycle
// restoring divider forms the quotient.
// Reset is synchronous and active low; it clears the sequencer, the output
// valid flag, the point counter and both seed registers.
// The output register lets the next beat be accepted while a result waits
// on i_out_stall; a finished result waits in its own state only while the
// output register is still held.

module numerov_recurrence_stepper (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  nrs_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output nrs_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_we,
    input  logic [nrs_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [nrs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int W     = nrs_pkg::WAVE_W;
    localparam int SW    = nrs_pkg::SEED_W;
    localparam int XW    = (W > SW) ? W : SW;
    localparam int PW    = W + (W % 2);
    localparam int HALF  = PW / 2;
    localparam int CNT_W = $clog2(HALF);
    localparam int KW    = nrs_pkg::COEF_W;
    localparam int F1_W  = KW + 5;
    localparam int DW    = KW + 1;
    localparam int ACC_W = KW + 8;
    localparam int MAG_W = KW;

    localparam logic signed [F1_W-1:0] ONE_F1 = F1_W'(1 << nrs_pkg::FRAC_BITS);
    localparam logic signed [DW-1:0]   ONE_D  = DW'(1 << nrs_pkg::FRAC_BITS);
    localparam logic [W-1:0]  POS_LIM   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  NEG_LIM   = {1'b1, {(W-1){1'b0}}};
    localparam logic [PW-1:0] POS_LIM_Q = PW'(POS_LIM);
    localparam logic [PW-1:0] NEG_LIM_Q = PW'(NEG_LIM);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HALF - 1);

    // Clip a seed to the wave range; the top bit of the result is the clip flag.
    function automatic logic [W:0] clip_seed(input logic [SW-1:0] seed);
        logic [XW-1:0] sx;
        logic [XW-W:0] top;
        logic          same;
        sx   = XW'($signed(seed));
        top  = sx[XW-1:W-1];
        same = (&top) | ~(|top);
        if (same) begin
            clip_seed = {1'b0, sx[W-1:0]};
        end else begin
            clip_seed = {1'b1, (seed[SW-1] ? NEG_LIM : POS_LIM)};
        end
    endfunction

    nrs_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    nrs_pkg::t_out   r_out, n_out;
    nrs_pkg::t_out   r_res, n_res;
    logic [1:0]      r_point_count, n_point_count;
    logic [SW-1:0]   r_seed_first, n_seed_first;
    logic [SW-1:0]   r_seed_second, n_seed_second;
    logic [KW-1:0]   r_coef_prev, n_coef_prev;
    logic [KW-1:0]   r_coef_cur, n_coef_cur;
    logic [KW-1:0]   r_k, n_k;
    logic [W-1:0]    r_wave_prev, n_wave_prev;
    logic [W-1:0]    r_wave_cur, n_wave_cur;

    logic signed [F1_W-1:0]  r_f1, n_f1;
    logic signed [DW-1:0]    r_f0, n_f0;
    logic [MAG_W-1:0]        r_den_mag, n_den_mag;
    logic                    r_den_neg, n_den_neg;
    logic                    r_zdiv, n_zdiv;
    logic                    r_nneg, n_nneg;
    logic                    r_carry, n_carry;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic [PW-1:0]           r_lo, n_lo;
    logic [PW-1:0]           r_p1, n_p1;
    logic [PW-1:0]           r_p0, n_p0;
    logic [MAG_W-1:0]        r_rem, n_rem;
    logic [CNT_W-1:0]        r_cnt, n_cnt;

    // Next state and datapath.
    always_comb begin
        logic [1:0]              pc_eff;
        logic [W:0]              clip;
        logic signed [DW-1:0]    den;
        logic signed [F1_W-1:0]  k1x;
        logic signed [ACC_W-1:0] t1, t0, term, sum, acc_v;
        logic [PW-1:0]           lo_v, p1_v, p0_v, qmag, qlim;
        logic [MAG_W-1:0]        rem_v;
        logic [MAG_W:0]          trial;
        logic                    ge, last, qneg, ovf, qsat;

        n_state       = r_state;
        n_out_valid   = r_out_valid;
        n_out         = r_out;
        n_res         = r_res;
        n_point_count = r_point_count;
        n_seed_first  = r_seed_first;
        n_seed_second = r_seed_second;
        n_coef_prev   = r_coef_prev;
        n_coef_cur    = r_coef_cur;
        n_k           = r_k;
        n_wave_prev   = r_wave_prev;
        n_wave_cur    = r_wave_cur;
        n_f1          = r_f1;
        n_f0          = r_f0;
        n_den_mag     = r_den_mag;
        n_den_neg     = r_den_neg;
        n_zdiv        = r_zdiv;
        n_nneg        = r_nneg;
        n_carry       = r_carry;
        n_acc         = r_acc;
        n_lo          = r_lo;
        n_p1          = r_p1;
        n_p0          = r_p0;
        n_rem         = r_rem;
        n_cnt         = r_cnt;

        pc_eff = 2'd0;
        clip   = '0;
        den    = '0;
        k1x    = '0;
        t1     = '0;
        t0     = '0;
        term   = '0;
        sum    = '0;
        acc_v  = r_acc;
        lo_v   = r_lo;
        p1_v   = r_p1;
        p0_v   = r_p0;
        qmag   = '0;
        qlim   = '0;
        rem_v  = r_rem;
        trial  = '0;
        ge     = 1'b0;
        last   = 1'b0;
        qneg   = 1'b0;
        ovf    = 1'b0;
        qsat   = 1'b0;

        // Configuration writes.
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                nrs_pkg::CFG_SEED_FIRST:  n_seed_first  = i_cfg_data[SW-1:0];
                nrs_pkg::CFG_SEED_SECOND: n_seed_second = i_cfg_data[SW-1:0];
                default: ;
            endcase
        end

        // The output beat leaves when the receiver does not stall.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            nrs_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    pc_eff        = i_in_data.restart ? 2'd0 : r_point_count;
                    n_point_count = (pc_eff == 2'd2) ? 2'd2 : pc_eff + 2'd1;
                    n_k           = i_in_data.coef_sample;
                    // Numerator factors and divisor, all Q.30.
                    k1x       = F1_W'($signed(r_coef_cur));
                    n_f1      = (ONE_F1 - ((k1x <<< 2) + k1x)) <<< 1;
                    n_f0      = DW'($signed(r_coef_prev)) + ONE_D;
                    den       = DW'(i_in_data.coef_sample) + ONE_D;
                    n_den_neg = den[DW-1];
                    n_zdiv    = (den == '0);
                    n_den_mag = MAG_W'(den[DW-1] ? -den : den);
                    n_acc     = '0;
                    n_lo      = '0;
                    n_p1      = PW'($signed(r_wave_cur));
                    n_p0      = PW'($signed(r_wave_prev));
                    n_cnt     = '0;
                    unique case (pc_eff)
                        2'd0: begin
                            clip    = clip_seed(r_seed_first);
                            n_res   = '{wave_value: clip[W-1:0], saturated: clip[W],
                                        zero_divisor: 1'b0};
                            n_state = nrs_pkg::ST_DONE;
                        end
                        2'd1: begin
                            clip    = clip_seed(r_seed_second);
                            n_res   = '{wave_value: clip[W-1:0], saturated: clip[W],
                                        zero_divisor: 1'b0};
                            n_state = nrs_pkg::ST_DONE;
                        end
                        default: n_state = nrs_pkg::ST_MUL;
                    endcase
                end
            end

            // Two multiplier bits of both products per cycle, LSB first; the
            // sign bit of the wave value carries negative weight.
            nrs_pkg::ST_MUL: begin
                for (int j = 0; j < 2; j++) begin
                    t1    = p1_v[0] ? ACC_W'(r_f1) : '0;
                    t0    = p0_v[0] ? ACC_W'(r_f0) : '0;
                    last  = (r_cnt == CNT_LAST) && (j == 1);
                    term  = last ? (t0 - t1) : (t1 - t0);
                    sum   = acc_v + term;
                    lo_v  = {sum[0], lo_v[PW-1:1]};
                    acc_v = sum >>> 1;
                    p1_v  = p1_v >> 1;
                    p0_v  = p0_v >> 1;
                end
                n_acc = acc_v;
                n_lo  = lo_v;
                n_p1  = p1_v;
                n_p0  = p0_v;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_nneg  = acc_v[ACC_W-1];
                    n_cnt   = '0;
                    n_state = nrs_pkg::ST_NEG_LO;
                end
            end

            // Magnitude of the numerator, low word then high word.
            nrs_pkg::ST_NEG_LO: begin
                n_carry = 1'b0;
                if (r_nneg) begin
                    n_lo    = ~r_lo + 1'b1;
                    n_carry = (r_lo == '0);
                end
                n_state = nrs_pkg::ST_NEG_HI;
            end

            nrs_pkg::ST_NEG_HI: begin
                if (r_nneg) begin
                    n_acc = ~r_acc + ACC_W'(r_carry);
                end
                n_cnt   = '0;
                n_state = nrs_pkg::ST_DIV;
            end

            // Restoring division, two quotient bits per cycle, MSB first. The
            // remainder starts from the high word of the magnitude.
            nrs_pkg::ST_DIV: begin
                rem_v = (r_cnt == '0) ? r_acc[MAG_W-1:0] : r_rem;
                for (int j = 0; j < 2; j++) begin
                    trial = {rem_v, lo_v[PW-1]};
                    ge    = (trial >= {1'b0, r_den_mag});
                    rem_v = ge ? MAG_W'(trial - {1'b0, r_den_mag}) : trial[MAG_W-1:0];
                    lo_v  = {lo_v[PW-2:0], ge};
                end
                n_rem = rem_v;
                n_lo  = lo_v;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = nrs_pkg::ST_FIN;
                end
            end

            // Sign, range clip and zero divisor. A high word at or above the
            // divisor means the quotient overflows the quotient register.
            nrs_pkg::ST_FIN: begin
                ovf   = ($unsigned(r_acc) >= ACC_W'(r_den_mag));
                qneg  = r_nneg ^ r_den_neg;
                qlim  = qneg ? NEG_LIM_Q : POS_LIM_Q;
                qsat  = ovf || (r_lo > qlim);
                qmag  = qneg ? (~r_lo + 1'b1) : r_lo;
                n_res = '{wave_value: (qsat ? (qneg ? NEG_LIM : POS_LIM) : qmag[W-1:0]),
                          saturated: qsat, zero_divisor: r_zdiv};
                n_state = nrs_pkg::ST_DONE;
            end

            // Hand the result to the output register and shift the history.
            nrs_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_wave_prev = r_wave_cur;
                    n_wave_cur  = r_res.wave_value;
                    n_coef_prev = r_coef_cur;
                    n_coef_cur  = r_k;
                    n_state     = nrs_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= nrs_pkg::ST_IDLE;
            r_out_valid   <= 1'b0;
            r_point_count <= 2'd0;
            r_seed_first  <= '0;
            r_seed_second <= '0;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_point_count <= n_point_count;
            r_seed_first  <= n_seed_first;
            r_seed_second <= n_seed_second;
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge i_clk) begin
        r_out       <= n_out;
        r_res       <= n_res;
        r_coef_prev <= n_coef_prev;
        r_coef_cur  <= n_coef_cur;
        r_k         <= n_k;
        r_wave_prev <= n_wave_prev;
        r_wave_cur  <= n_wave_cur;
        r_f1        <= n_f1;
        r_f0        <= n_f0;
        r_den_mag   <= n_den_mag;
        r_den_neg   <= n_den_neg;
        r_zdiv      <= n_zdiv;
        r_nneg      <= n_nneg;
        r_carry     <= n_carry;
        r_acc       <= n_acc;
        r_lo        <= n_lo;
        r_p1        <= n_p1;
        r_p0        <= n_p0;
        r_rem       <= n_rem;
        r_cnt       <= n_cnt;
    end

    assign o_in_stall  = (r_state != nrs_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // An accepted beat always starts work.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != nrs_pkg::ST_IDLE))
        else $error("accepted beat did not start work");

    // A finished result reaches the output register once the slot is free.
    a_done_hands_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nrs_pkg::ST_DONE && (!r_out_valid || !i_out_stall))
        |=> (o_out_valid && r_state == nrs_pkg::ST_IDLE))
        else $error("finished result was not handed to the output");

    // A zero divisor always comes out saturated.
    a_zdiv_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.zero_divisor) |-> o_out_data.saturated)
        else $error("zero divisor without saturation");

    // A saturated value is one of the two range limits.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.saturated)
        |-> (o_out_data.wave_value == POS_LIM || o_out_data.wave_value == NEG_LIM))
        else $error("saturated value is not a range limit");

    // The point counter stops at two.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_point_count != 2'd3)
        else $error("point counter out of range");

endmodule

FILE: tb/nrs_checker.sv
`timescale 1ns / 1ps

module nrs_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  nrs_pkg::t_in                   i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  nrs_pkg::t_out                  i_out_data,
    input  logic                           i_cfg_we,
    input  logic [nrs_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [nrs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_sat_seen,
    output int                             o_zdiv_seen
);

    // Fixed-point constants, held at a width that fits the full numerator.
    localparam logic signed [127:0] FIX_ONE  = 128'sd1 <<< nrs_pkg::FRAC_BITS;
    localparam logic signed [127:0] WAVE_MAX =
        (128'sd1 <<< (nrs_pkg::WAVE_W - 1)) - 128'sd1;
    localparam logic signed [127:0] WAVE_MIN = -(128'sd1 <<< (nrs_pkg::WAVE_W - 1));

    // Shadow copy of the seed registers and the recurrence history.
    logic signed [nrs_pkg::SEED_W-1:0] seed_first;
    logic signed [nrs_pkg::SEED_W-1:0] seed_second;
    logic signed [nrs_pkg::COEF_W-1:0] coef_prev;
    logic signed [nrs_pkg::COEF_W-1:0] coef_cur;
    logic signed [nrs_pkg::WAVE_W-1:0] wave_prev;
    logic signed [nrs_pkg::WAVE_W-1:0] wave_cur;
    logic [1:0]                        points_seen;

    // Predicted wavefunction beats, oldest first.
    nrs_pkg::t_out wave_expected[$];

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // Clip a wide signed value into the wave range and flag any clipping.
    function automatic nrs_pkg::t_out clip_wave(input logic signed [127:0] v);
        nrs_pkg::t_out res;
        res = '0;
        if (v > WAVE_MAX) begin
            v = WAVE_MAX;
            res.saturated = 1'b1;
        end else if (v < WAVE_MIN) begin
            v = WAVE_MIN;
            res.saturated = 1'b1;
        end
        res.wave_value = v[nrs_pkg::WAVE_W-1:0];
        return res;
    endfunction

    // Work out the wavefunction value of one grid point and advance the history.
    function automatic nrs_pkg::t_out step_point(input nrs_pkg::t_in beat);
        nrs_pkg::t_out       res;
        logic signed [127:0] p1;
        logic signed [127:0] p0;
        logic signed [127:0] k1;
        logic signed [127:0] k0;
        logic signed [127:0] k2;
        logic signed [127:0] num;
        logic signed [127:0] den;
        if (beat.restart) begin
            points_seen = 2'd0;
        end
        if (points_seen == 2'd0) begin
            res = clip_wave($signed(seed_first));
        end else if (points_seen == 2'd1) begin
            res = clip_wave($signed(seed_second));
        end else begin
            p1  = wave_cur;
            p0  = wave_prev;
            k1  = coef_cur;
            k0  = coef_prev;
            k2  = $signed(beat.coef_sample);
            num = 128'sd2 * p1 * (FIX_ONE - 128'sd5 * k1) - p0 * (FIX_ONE + k0);
            den = FIX_ONE + k2;
            if (den == 128'sd0) begin
                // Division by zero goes to the limit that matches the numerator sign.
                res = clip_wave((num < 128'sd0) ? WAVE_MIN : WAVE_MAX);
                res.saturated    = 1'b1;
                res.zero_divisor = 1'b1;
            end else begin
                // Signed division truncates toward zero, as the block does.
                res = clip_wave(num / den);
            end
        end
        coef_prev = coef_cur;
        coef_cur  = beat.coef_sample;
        wave_prev = wave_cur;
        wave_cur  = res.wave_value;
        if (points_seen < 2'd2) begin
            points_seen = points_seen + 2'd1;
        end
        return res;
    endfunction

    // Watch both channels and the register port at every rising edge.
    always @(posedge i_clk) begin : watch
        nrs_pkg::t_out want;
        nrs_pkg::t_out got;
        nrs_pkg::t_out pred;
        if (!i_rst_n) begin
            seed_first  = '0;
            seed_second = '0;
            coef_prev   = '0;
            coef_cur    = '0;
            wave_prev   = '0;
            wave_cur    = '0;
            points_seen = 2'd0;
            wave_expected.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    nrs_pkg::CFG_SEED_FIRST: begin
                        seed_first = i_cfg_data[nrs_pkg::SEED_W-1:0];
                    end
                    nrs_pkg::CFG_SEED_SECOND: begin
                        seed_second = i_cfg_data[nrs_pkg::SEED_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // Output beat: compare against the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (wave_expected.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d arrived with nothing pending",
                                              o_checked));
                end else begin
                    want = wave_expected.pop_front();
                    if (got.wave_value !== want.wave_value) begin
                        report_mismatch($sformatf("beat %0d wave_value %h, predicted %h",
                                                  o_checked, got.wave_value, want.wave_value));
                    end
                    if (got.saturated !== want.saturated) begin
                        report_mismatch($sformatf("beat %0d saturated %b, predicted %b",
                                                  o_checked, got.saturated, want.saturated));
                    end
                    if (got.zero_divisor !== want.zero_divisor) begin
                        report_mismatch($sformatf("beat %0d zero_divisor %b, predicted %b",
                                                  o_checked, got.zero_divisor,
                                                  want.zero_divisor));
                    end
                    if (want.saturated) begin
                        o_sat_seen++;
                    end
                    if (want.zero_divisor) begin
                        o_zdiv_seen++;
                    end
                end
                o_checked++;
            end
            // Input beat: predict its result and queue it behind the others.
            if (i_in_valid && !i_in_stall) begin
                pred          = step_point(i_in_data);
                wave_expected = {wave_expected, pred};
            end
        end
        o_pending = wave_expected.size();
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int                             CYCLE_LIMIT   = 600000;
    localparam int                             PHASE_BEATS   = 250;
    localparam int                             DRAIN_CYCLES  = 60;
    localparam logic [nrs_pkg::CFG_ADDR_W-1:0] CFG_UNUSED    = 2'd3;
    localparam logic [nrs_pkg::COEF_W-1:0]     COEF_MAX      = 32'h7FFF_FFFF;
    localparam logic [nrs_pkg::COEF_W-1:0]     COEF_MIN      = 32'h8000_0000;
    localparam logic [nrs_pkg::COEF_W-1:0]     COEF_MINUS_1  = 32'hC000_0000;
    localparam logic [nrs_pkg::SEED_W-1:0]     SEED_MAX      =
        {1'b0, {(nrs_pkg::SEED_W - 1){1'b1}}};
    localparam logic [nrs_pkg::SEED_W-1:0]     SEED_MIN      =
        {1'b1, {(nrs_pkg::SEED_W - 1){1'b0}}};
    localparam logic [nrs_pkg::SEED_W-1:0]     SEED_ONE      = 48'd1 << nrs_pkg::FRAC_BITS;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    nrs_pkg::t_in                   i_in_data;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    nrs_pkg::t_out                  o_out_data;
    logic                           i_cfg_we;
    logic [nrs_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [nrs_pkg::CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int checked;
    int sat_seen;
    int zdiv_seen;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int beats_sent    = 0;
    int cycle_count   = 0;

    numerov_recurrence_stepper u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    nrs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_sat_seen   (sat_seen),
        .o_zdiv_seen  (zdiv_seen)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[numerov_recurrence_stepper] ERROR");
            $finish;
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // Present one coefficient beat and hold it until it is taken.
    // Entered and left at a falling edge.
    task automatic send_point(input logic [nrs_pkg::COEF_W-1:0] coef, input logic restart);
        nrs_pkg::t_in beat;
        beat.coef_sample = coef;
        beat.restart     = restart;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        beats_sent++;
    endtask

    // Drop valid and wait until every predicted result has been taken.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [nrs_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [nrs_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Seed values: mostly moderate magnitudes, sometimes the range limits.
    function automatic logic [nrs_pkg::SEED_W-1:0] rand_seed();
        logic signed [63:0] r;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            return SEED_MAX;
        end else if (pick < 16) begin
            return SEED_MIN;
        end
        r = {$urandom, $urandom};
        r = r >>> $urandom_range(16, 44);
        return r[nrs_pkg::SEED_W-1:0];
    endfunction

    // Coefficients of a plausible potential, with occasional k = -1 and wild values.
    function automatic logic [nrs_pkg::COEF_W-1:0] physical_coef();
        logic signed [nrs_pkg::COEF_W-1:0] c;
        int                                pick;
        pick = $urandom_range(99);
        if (pick < 3) begin
            return COEF_MINUS_1;
        end else if (pick < 6) begin
            return $urandom;
        end
        c = $urandom;
        return c >>> $urandom_range(3, 14);
    endfunction

    initial begin : stimulus
        int target;
        int len;
        int i;
        int ph;
        int idle_tab[4];
        int stall_tab[4];
        idle_tab  = '{0, 56, 0, 33};
        stall_tab = '{0, 0, 56, 33};

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // First beats after reset count as a new sequence without restart;
        // zero seeds then give a zero numerator against a zero divisor.
        send_point(32'd0, 1'b0);
        send_point(32'd5, 1'b0);
        send_point(COEF_MINUS_1, 1'b0);

        // Extreme seeds and extreme coefficients; an unused index is ignored.
        wait_drained();
        write_reg(CFG_UNUSED, {nrs_pkg::CFG_DATA_W{1'b1}});
        write_reg(nrs_pkg::CFG_SEED_FIRST, SEED_MAX);
        write_reg(nrs_pkg::CFG_SEED_SECOND, SEED_MIN);
        send_point(COEF_MAX, 1'b1);
        send_point(COEF_MIN, 1'b0);
        send_point(32'd0, 1'b0);
        send_point(COEF_MAX, 1'b0);
        send_point(32'hFFFF_FFFF, 1'b0);

        // Negative numerator into a zero divisor, then a restart mid-sequence.
        wait_drained();
        write_reg(nrs_pkg::CFG_SEED_FIRST, SEED_ONE);
        write_reg(nrs_pkg::CFG_SEED_SECOND, '0);
        send_point(32'd0, 1'b1);
        send_point(32'd0, 1'b0);
        send_point(COEF_MINUS_1, 1'b0);
        send_point(32'd123, 1'b1);
        send_point(32'h0010_0000, 1'b0);
        send_point(32'hFFF0_0000, 1'b0);

        // A short ordinary run with small coefficients.
        wait_drained();
        write_reg(nrs_pkg::CFG_SEED_SECOND, SEED_ONE + 48'd4096);
        send_point(32'h0004_0000, 1'b1);
        send_point(32'h0004_0000, 1'b0);
        send_point(32'h0003_0000, 1'b0);
        send_point(32'hFFFE_0000, 1'b0);
        send_point(32'hFFF0_0000, 1'b0);

        // Random traffic: mostly restart-led sequences, some loose noise beats.
        for (ph = 0; ph < 4; ph++) begin
            wait_drained();
            in_idle_pct   = idle_tab[ph];
            out_stall_pct = stall_tab[ph];
            write_reg(nrs_pkg::CFG_SEED_FIRST, rand_seed());
            write_reg(nrs_pkg::CFG_SEED_SECOND, rand_seed());
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target) begin
                if ($urandom_range(99) < 85) begin
                    len = $urandom_range(2, 30);
                    for (i = 0; i < len; i++) begin
                        send_point(physical_coef(), i == 0);
                    end
                end else begin
                    send_point($urandom, 1'($urandom_range(1)));
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d coefficient beats in 4 traffic phases, %0d results checked.",
                 beats_sent, checked);
        $display("Results with clipping: %0d, with a zero divisor: %0d.", sat_seen, zdiv_seen);
        if (fail_count == 0) begin
            $display("[numerov_recurrence_stepper] OK");
        end else begin
            $display("[numerov_recurrence_stepper] ERROR");
        end
        $finish;
    end

endmodule
